// File: src/aabb_pkg.sv
// Shared types and constants for the box table query block.
`default_nettype none
package aabb_pkg;
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int HIT_CAP = 32;

  typedef enum logic [2:0] {
    ACT_REGISTER = 3'd0,
    ACT_UNREGISTER = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_QUERY = 3'd3,
    ACT_CHECK = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,      // scan for shape_id (and other_id)
    ST_DECIDE,
    ST_SHIFT,     // unregister compaction
    ST_QUERY,     // query scan, one entry per cycle
    ST_QEND,
    ST_CHK_A,
    ST_CHK_B,
    ST_CHK_EVAL
  } state_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic latch;       // capture request fields
    logic scan_clr;    // clear scan index and find flags
    logic scan_step;   // advance scan index, record id matches
    logic do_append;   // write new entry at entry_total
    logic do_update;   // rewrite matched entry
    logic shift_load;  // point scan index at the removed slot
    logic shift_step;  // move entry idx+1 down to idx
    logic shift_done;  // drop entry_total
    logic q_step;      // evaluate one entry of a query
    logic rd_a;        // read matched slot of shape_id
    logic rd_b;        // read matched slot of other_id
    logic emit_plain;  // emit single result
    logic emit_qend;   // emit final query result, with any held-back hit
    logic emit_chk;    // emit check pair result
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    action_t act;
    logic scan_end;    // scan index reached entry_total
    logic found_a;
    logic found_b;
    logic full;
    logic id_zero;
    logic shift_end;
    logic q_end;       // scan ended or limit reached, no read in flight
  } stat_t;

  function automatic logic boxes_meet(
    input logic signed [16:0] ax, input logic signed [16:0] ay,
    input logic signed [16:0] aw, input logic signed [16:0] ah,
    input logic signed [16:0] bx, input logic signed [16:0] by,
    input logic signed [16:0] bw, input logic signed [16:0] bh);
    logic signed [17:0] axe, aye, bxe, bye;
    begin
      axe = ax + aw;
      aye = ay + ah;
      bxe = bx + bw;
      bye = by + bh;
      return (18'(ax) < bxe) && (axe > 18'(bx)) && (18'(ay) < bye) && (aye > 18'(by));
    end
  endfunction
endpackage
`default_nettype wire

// File: src/aabb_ctrl.sv
// Controller state machine for the box table.
`default_nettype none
module aabb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire aabb_pkg::stat_t st,
  output aabb_pkg::cmd_t      cmd
);
  aabb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= aabb_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aabb_pkg::ST_IDLE: if (start) state_next = aabb_pkg::ST_FIND;
      aabb_pkg::ST_FIND: begin
        if (st.act == aabb_pkg::ACT_QUERY) state_next = aabb_pkg::ST_QUERY;
        else if (st.scan_end) state_next = aabb_pkg::ST_DECIDE;
      end
      aabb_pkg::ST_DECIDE: begin
        if (st.act == aabb_pkg::ACT_UNREGISTER && st.found_a)
          state_next = aabb_pkg::ST_SHIFT;
        else if (st.act == aabb_pkg::ACT_CHECK && st.found_a && st.found_b)
          state_next = aabb_pkg::ST_CHK_A;
        else state_next = aabb_pkg::ST_IDLE;
      end
      aabb_pkg::ST_SHIFT: if (st.shift_end) state_next = aabb_pkg::ST_IDLE;
      aabb_pkg::ST_QUERY: if (st.q_end) state_next = aabb_pkg::ST_QEND;
      aabb_pkg::ST_QEND: state_next = aabb_pkg::ST_IDLE;
      aabb_pkg::ST_CHK_A: state_next = aabb_pkg::ST_CHK_B;
      aabb_pkg::ST_CHK_B: state_next = aabb_pkg::ST_CHK_EVAL;
      aabb_pkg::ST_CHK_EVAL: state_next = aabb_pkg::ST_IDLE;
      default: state_next = aabb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != aabb_pkg::ST_IDLE);
    unique case (state)
      aabb_pkg::ST_IDLE: begin
        cmd.latch = start;
        cmd.scan_clr = start;
      end
      aabb_pkg::ST_FIND: cmd.scan_step = (st.act != aabb_pkg::ACT_QUERY) && !st.scan_end;
      aabb_pkg::ST_DECIDE: begin
        case (st.act)
          aabb_pkg::ACT_REGISTER: begin
            cmd.do_append = !st.id_zero && !st.full && !st.found_a;
            cmd.emit_plain = 1'b1;
          end
          aabb_pkg::ACT_UNREGISTER: begin
            cmd.emit_plain = !st.found_a;
            cmd.shift_load = st.found_a;
          end
          aabb_pkg::ACT_UPDATE: begin
            cmd.do_update = st.found_a;
            cmd.emit_plain = 1'b1;
          end
          aabb_pkg::ACT_CHECK: cmd.emit_plain = !(st.found_a && st.found_b);
          default: cmd.emit_plain = 1'b1;
        endcase
      end
      aabb_pkg::ST_SHIFT: begin
        cmd.shift_step = !st.shift_end;
        cmd.shift_done = st.shift_end;
        cmd.emit_plain = st.shift_end;
      end
      aabb_pkg::ST_QUERY: cmd.q_step = 1'b1;
      aabb_pkg::ST_QEND: cmd.emit_qend = 1'b1;
      aabb_pkg::ST_CHK_A: cmd.rd_a = 1'b1;
      aabb_pkg::ST_CHK_B: cmd.rd_b = 1'b1;
      aabb_pkg::ST_CHK_EVAL: cmd.emit_chk = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: src/aabb_dpath.sv
// Datapath: entry table, scan index, overlap test and result registers.
`default_nettype none
module aabb_dpath #(
  parameter int TABLE_DEPTH = aabb_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire aabb_pkg::cmd_t     cmd,
  output aabb_pkg::stat_t         st,
  input  wire logic [2:0]         action,
  input  wire logic [15:0]        shape_id,
  input  wire logic [15:0]        other_id,
  input  wire logic signed [15:0] box_x,
  input  wire logic signed [15:0] box_y,
  input  wire logic [14:0]        box_w,
  input  wire logic [14:0]        box_h,
  input  wire logic [31:0]        layer_bits,
  input  wire logic               enabled,
  input  wire logic [5:0]         hit_limit,
  output logic                    strobe,
  output logic                    status,
  output logic                    hit_valid,
  output logic [15:0]             hit_id,
  output logic [5:0]              hit_count,
  output logic                    overlaps,
  output logic                    last
);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // entry record: id, x, y, w, h, layers, enable
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [31:0] layers;
    logic        en;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd;
  logic [CW-1:0] total;
  logic [CW-1:0] idx;
  logic [IW-1:0] slot_a, slot_b;
  logic found_a, found_b;

  // latched request
  logic [2:0]  r_act;
  logic [15:0] r_id, r_oth;
  logic [15:0] r_x, r_y;
  logic [14:0] r_w, r_h;
  logic [31:0] r_lay;
  logic        r_en;
  logic [5:0]  r_lim;
  logic [5:0]  cnt;
  entry_t      ent_a;

  // pipelined query: read stage then test stage
  logic   q_rv;
  logic [CW-1:0] q_ridx;
  logic   q_hit;
  logic   q_fire;
  logic   pend_v;
  logic [15:0] pend_id;

  logic [IW-1:0] rd_addr;
  logic scan_end, lim_hit, shift_go;

  assign scan_end = (idx >= total);
  assign lim_hit = (cnt >= r_lim);
  // another entry above idx is left to move down
  assign shift_go = (idx + CW'(1) < total);

  always_comb begin
    rd_addr = idx[IW-1:0];
    if (cmd.rd_a) rd_addr = slot_a;
    else if (cmd.rd_b) rd_addr = slot_b;
    else if (cmd.shift_step) rd_addr = IW'(idx + CW'(1));
  end

  always_ff @(posedge clk) begin
    rd <= mem[rd_addr];
    if (cmd.do_append)
      mem[total[IW-1:0]] <= '{r_id, r_x, r_y, r_w, r_h, r_lay, r_en};
    else if (cmd.do_update)
      mem[slot_a] <= '{r_id, r_x, r_y, r_w, r_h, r_lay, r_en};
    else if (cmd.shift_step && q_rv)
      mem[IW'(q_ridx)] <= rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      r_act <= action; r_id <= shape_id; r_oth <= other_id;
      r_x <= box_x; r_y <= box_y; r_w <= box_w; r_h <= box_h;
      r_lay <= layer_bits; r_en <= enabled;
      r_lim <= (hit_limit > 6'(aabb_pkg::HIT_CAP)) ? 6'(aabb_pkg::HIT_CAP) : hit_limit;
    end
    if (cmd.rd_b) ent_a <= rd;
    if (q_fire) pend_id <= rd.id;
  end

  // query test runs on a registered read: rd holds entry q_ridx
  always_comb begin
    q_hit = q_rv && rd.en && ((rd.layers & r_lay) != 32'd0) &&
      aabb_pkg::boxes_meet($signed({r_x[15], r_x}), $signed({r_y[15], r_y}),
        $signed({2'b00, r_w}), $signed({2'b00, r_h}),
        $signed({rd.x[15], rd.x}), $signed({rd.y[15], rd.y}),
        $signed({2'b00, rd.w}), $signed({2'b00, rd.h}));
    q_fire = cmd.q_step && q_hit && !lim_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0; idx <= '0; q_rv <= 1'b0; found_a <= 1'b0; found_b <= 1'b0;
      cnt <= '0; pend_v <= 1'b0; strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cmd.scan_clr) begin
        idx <= '0; q_rv <= 1'b0; found_a <= 1'b0; found_b <= 1'b0;
        cnt <= '0; pend_v <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx <= idx + CW'(1);
        q_rv <= 1'b1; q_ridx <= idx;
      end else if (!cmd.q_step && !cmd.shift_step) q_rv <= 1'b0;
      // matches are checked in the cycle after the read is issued
      if ((cmd.scan_step || st.scan_end) && q_rv && !found_a && r_id != 16'd0 &&
          rd.id == r_id) begin
        found_a <= 1'b1; slot_a <= IW'(q_ridx);
      end
      if ((cmd.scan_step || st.scan_end) && q_rv && !found_b && r_oth != 16'd0 &&
          rd.id == r_oth) begin
        found_b <= 1'b1; slot_b <= IW'(q_ridx);
      end
      if (cmd.do_append) total <= total + CW'(1);
      // compaction starts at the removed slot
      if (cmd.shift_load) begin
        idx <= CW'(slot_a); q_rv <= 1'b0;
      end
      if (cmd.shift_step) begin
        if (shift_go) begin
          idx <= idx + CW'(1);
          q_rv <= 1'b1; q_ridx <= idx;
        end else q_rv <= 1'b0;
      end
      if (cmd.shift_done) total <= total - CW'(1);
      if (cmd.q_step) begin
        if (!scan_end && !lim_hit) begin
          idx <= idx + CW'(1); q_rv <= 1'b1; q_ridx <= idx;
        end else q_rv <= 1'b0;
        if (q_fire) begin
          // a hit is held back until the next one so the final one carries last
          if (pend_v) begin
            strobe <= 1'b1; status <= 1'b0; hit_valid <= 1'b1; hit_id <= pend_id;
            hit_count <= cnt; overlaps <= 1'b0; last <= 1'b0;
          end
          pend_v <= 1'b1;
          cnt <= cnt + 6'd1;
        end
      end
      if (cmd.emit_qend) begin
        strobe <= 1'b1; status <= 1'b0; overlaps <= 1'b0; last <= 1'b1;
        hit_valid <= pend_v; hit_id <= pend_v ? pend_id : 16'd0; hit_count <= cnt;
      end
      if (cmd.emit_plain) begin
        strobe <= 1'b1; hit_valid <= 1'b0; hit_id <= '0; hit_count <= '0;
        overlaps <= 1'b0; last <= 1'b1;
        case (r_act) inside
          aabb_pkg::ACT_REGISTER:
            status <= (r_id == 16'd0) || (total >= CW'(TABLE_DEPTH)) || found_a;
          aabb_pkg::ACT_UNREGISTER, aabb_pkg::ACT_UPDATE: status <= !found_a;
          aabb_pkg::ACT_CHECK: status <= 1'b1;
          default: status <= 1'b1;
        endcase
      end
      if (cmd.emit_chk) begin
        strobe <= 1'b1; status <= 1'b0; hit_valid <= 1'b0; hit_id <= '0;
        hit_count <= '0; last <= 1'b1;
        overlaps <= aabb_pkg::boxes_meet(
          $signed({ent_a.x[15], ent_a.x}), $signed({ent_a.y[15], ent_a.y}),
          $signed({2'b00, ent_a.w}), $signed({2'b00, ent_a.h}),
          $signed({rd.x[15], rd.x}), $signed({rd.y[15], rd.y}),
          $signed({2'b00, rd.w}), $signed({2'b00, rd.h}));
      end
    end
  end

  // the last id match is checked in the cycle that sees scan_end
  always_comb begin
    st.act = aabb_pkg::action_t'(r_act);
    st.scan_end = scan_end;
    st.found_a = found_a;
    st.found_b = found_b;
    st.full = (total >= CW'(TABLE_DEPTH));
    st.id_zero = (r_id == 16'd0);
    st.shift_end = !shift_go && !q_rv;
    st.q_end = (scan_end || lim_hit) && !q_rv;
  end
endmodule
`default_nettype wire

// File: src/aabb_shape_table_query.sv
// Top level of the ordered collision-box table with overlap queries.
`default_nettype none
// Usage:
//  A request is taken at a rising edge with start high and busy low. The
//  action field selects register, unregister, update, query or check pair.
//  Results appear on the result ports for one cycle each, marked by strobe;
//  last marks the final result of a request. The receiver cannot stall.
//  One request at a time. Every action but query scans the id column through
//  the single registered read port of the entry memory, one entry per cycle;
//  the result appears in the cycle in which busy drops. Unregister then moves
//  each later entry down, one per cycle. Check pair then reads both boxes in
//  ST_CHK_A and ST_CHK_B and tests them in ST_CHK_EVAL. A query walk ends
//  early when the hit limit is reached; hits stream out during the walk and
//  the final result appears in the cycle in which busy drops. Reset clears
//  the entry count and the scan state; the table memory holds no reset value
//  and needs no clearing pass.
module aabb_shape_table_query #(
  parameter int TABLE_DEPTH = aabb_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         action,
  input  wire logic [15:0]        shape_id,
  input  wire logic [15:0]        other_id,
  input  wire logic signed [15:0] box_x,
  input  wire logic signed [15:0] box_y,
  input  wire logic [14:0]        box_w,
  input  wire logic [14:0]        box_h,
  input  wire logic [31:0]        layer_bits,
  input  wire logic               enabled,
  input  wire logic [5:0]         hit_limit,
  output logic                    strobe,
  output logic                    status,
  output logic                    hit_valid,
  output logic [15:0]             hit_id,
  output logic [5:0]              hit_count,
  output logic                    overlaps,
  output logic                    last
);
  aabb_pkg::cmd_t  cmd;
  aabb_pkg::stat_t st;

  aabb_ctrl u_ctrl (.clk, .rst, .start, .busy, .st, .cmd);

  aabb_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
    .clk, .rst, .cmd, .st, .action, .shape_id, .other_id, .box_x, .box_y,
    .box_w, .box_h, .layer_bits, .enabled, .hit_limit, .strobe, .status,
    .hit_valid, .hit_id, .hit_count, .overlaps, .last
  );
endmodule
`default_nettype wire

// File: src/aabb_checker.sv
// Port-level checker for the box table, bound to the top level.
`default_nettype none
module aabb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic       status,
  input wire logic       hit_valid,
  input wire logic [5:0] hit_count,
  input wire logic       last
);
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request did not raise busy");
  a_hit_count: assert property (@(posedge clk) disable iff (rst)
    strobe && hit_valid |-> hit_count != 6'd0) else $error("hit with zero count");
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    strobe && hit_valid |-> !status) else $error("hit with status set");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe) else $error("result while idle");
  a_plain_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !hit_valid |-> last) else $error("non-hit result without last");
endmodule

bind aabb_shape_table_query aabb_checker u_chk (.clk, .rst, .start, .busy,
  .strobe, .status, .hit_valid, .hit_count, .last);
`default_nettype wire
